// ----- src/omt_pkg.sv -----
package omt_pkg;

  // Fixed field widths of the bus item and the result item.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OFF_W   = 6;
  localparam int unsigned BYTES_W = 3;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IRQ_W   = 4;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_MATCH_DEF   = 4;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Only full word accesses act on the registers.
  localparam logic [BYTES_W-1:0] ACCESS_WORD = 3'd4;

  // Register word offsets. Match registers occupy offsets 0 to 3.
  localparam logic [OFF_W-1:0] OFF_COUNTER = 6'd4;
  localparam logic [OFF_W-1:0] OFF_STATUS  = 6'd5;
  localparam logic [OFF_W-1:0] OFF_WDOG_EN = 6'd6;
  localparam logic [OFF_W-1:0] OFF_IRQ_EN  = 6'd7;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [OFF_W-1:0]   word_offset;
    logic [BYTES_W-1:0] access_bytes;
    logic [DATA_W-1:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_lines;
  } result_t;

endpackage

// ----- src/os_match_timer_regs_unit.sv -----
// OS timer with a free-running counter, match registers, a sticky match
// status word, an interrupt-enable word and a stored watchdog-enable word.
// Every bus read, bus write and timer tick arrives as one item on the input
// channel (valid/ready), and every item yields exactly one result item on
// the output channel: the read data (zero for anything but a word read) and
// the interrupt lines, which show the status bits after that item.
// An accepted item lands in an input register; when it moves forward, the core
// applies it to the timer state and the result is captured in the output
// register. Throughput is one item per cycle while the receiver takes each
// result: the input register moves forward whenever the output register
// is empty or is being emptied in the same cycle, so a new item is taken
// while the previous one is being delivered.
// When the receiver stalls, the output register holds its result, the input
// register fills, and ready drops until the receiver takes the result.
// Reset clears the counter, match values, status and both enable words,
// and empties both registers.
module os_match_timer_regs_unit #(
  parameter int unsigned NUM_MATCH   = omt_pkg::NUM_MATCH_DEF,
  parameter int unsigned COUNT_WIDTH = omt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [omt_pkg::OP_W-1:0]     operation_i,
  input  logic [omt_pkg::OFF_W-1:0]    word_offset_i,
  input  logic [omt_pkg::BYTES_W-1:0]  access_bytes_i,
  input  logic [omt_pkg::DATA_W-1:0]   write_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [omt_pkg::DATA_W-1:0]   read_data_o,
  output logic [omt_pkg::IRQ_W-1:0]    irq_lines_o
);
  import omt_pkg::*;

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  result_t core_result;
  logic    advance;

  // The staged item moves into the output register when that register is
  // free or is being drained in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.operation    <= operation_i;
      item_q.word_offset  <= word_offset_i;
      item_q.access_bytes <= access_bytes_i;
      item_q.write_data   <= write_data_i;
    end
  end

  omt_core #(
    .NUM_MATCH   (NUM_MATCH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .result_o (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= core_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = result_q.read_data;
  assign irq_lines_o = result_q.irq_lines;

endmodule

// ----- src/omt_core.sv -----
module omt_core #(
  parameter int unsigned NUM_MATCH   = omt_pkg::NUM_MATCH_DEF,
  parameter int unsigned COUNT_WIDTH = omt_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  omt_pkg::item_t  item_i,
  output omt_pkg::result_t result_o
);
  import omt_pkg::*;

  logic [COUNT_WIDTH-1:0] counter_q, counter_d;
  logic [COUNT_WIDTH-1:0] match_q [NUM_MATCH];
  logic [COUNT_WIDTH-1:0] match_d [NUM_MATCH];
  logic [NUM_MATCH-1:0]   status_q, status_d;
  logic [DATA_W-1:0]      wdog_en_q, wdog_en_d;
  logic [DATA_W-1:0]      irq_en_q, irq_en_d;
  logic [DATA_W-1:0]      rd_data;
  logic                   is_word;
  logic                   check;

  assign is_word = (item_i.access_bytes == ACCESS_WORD);

  always_comb begin
    counter_d = counter_q;
    match_d   = match_q;
    status_d  = status_q;
    wdog_en_d = wdog_en_q;
    irq_en_d  = irq_en_q;
    rd_data   = '0;
    check     = 1'b0;
    case (item_i.operation)
      OP_TICK: begin
        counter_d = counter_q + COUNT_WIDTH'(1);
        check     = 1'b1;
      end
      OP_READ: begin
        if (is_word) begin
          for (int ch = 0; ch < NUM_MATCH; ch++) begin
            if (item_i.word_offset == OFF_W'(ch)) begin
              rd_data = DATA_W'(match_q[ch]);
            end
          end
          case (item_i.word_offset)
            OFF_COUNTER: rd_data = DATA_W'(counter_q);
            OFF_STATUS:  rd_data = DATA_W'(status_q);
            OFF_WDOG_EN: rd_data = wdog_en_q;
            OFF_IRQ_EN:  rd_data = irq_en_q;
            default:     ;
          endcase
        end
      end
      OP_WRITE: begin
        if (is_word) begin
          for (int ch = 0; ch < NUM_MATCH; ch++) begin
            if (item_i.word_offset == OFF_W'(ch)) begin
              match_d[ch] = item_i.write_data[COUNT_WIDTH-1:0];
            end
          end
          case (item_i.word_offset)
            OFF_COUNTER: counter_d = item_i.write_data[COUNT_WIDTH-1:0];
            OFF_STATUS:  status_d  = status_q & ~item_i.write_data[NUM_MATCH-1:0];
            OFF_WDOG_EN: wdog_en_d = item_i.write_data;
            OFF_IRQ_EN: begin
              irq_en_d = item_i.write_data;
              check    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // Match compare: match values are unchanged whenever a compare is due.
    if (check) begin
      for (int ch = 0; ch < NUM_MATCH; ch++) begin
        if ((counter_d == match_q[ch]) && irq_en_d[ch]) begin
          status_d[ch] = 1'b1;
        end
      end
    end
  end

  assign result_o.read_data = rd_data;
  assign result_o.irq_lines = IRQ_W'(status_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      for (int ch = 0; ch < NUM_MATCH; ch++) begin
        match_q[ch] <= '0;
      end
      status_q  <= '0;
      wdog_en_q <= '0;
      irq_en_q  <= '0;
    end else if (fire_i) begin
      counter_q <= counter_d;
      match_q   <= match_d;
      status_q  <= status_d;
      wdog_en_q <= wdog_en_d;
      irq_en_q  <= irq_en_d;
    end
  end

endmodule
